// File: hdl/prim_mst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prim spanning tree package
// Shared constants, word layouts and control groups of the spanning tree block.
// ----------------------------------------------------------------------------
package prim_mst_pkg;

   localparam int unsigned VERTEX_COUNT_DEF = 8;

   localparam int unsigned KEY_W = 10;
   localparam int unsigned PAR_W = 4;
   localparam int unsigned VTX_W = 3;

   localparam logic [KEY_W-1:0] KEY_NONE = 10'd1000;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   // One vertex entry: visited flag, parent plus one and current key.
   typedef struct packed {
      logic             visited;
      logic [PAR_W-1:0] parent;
      logic [KEY_W-1:0] key;
   } vert_word_type;

   localparam int unsigned VERT_W = $bits(vert_word_type);

   // Operand selection for the shared key comparator.
   typedef struct packed {
      logic             relax;
      logic             is_best;
      logic [KEY_W-1:0] best_key;
      logic [KEY_W-1:0] weight;
   } cmp_ctl_type;

endpackage : prim_mst_pkg
`default_nettype wire

// File: hdl/prim_mst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prim spanning tree RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prim_mst_ram
   import prim_mst_pkg::*;
#(
   parameter int unsigned DEPTH = VERTEX_COUNT_DEF,
   parameter int unsigned WIDTH = VERT_W,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire              clock,
   input  wire              wr_en,
   input  wire  [AW-1:0]    wr_addr,
   input  wire  [WIDTH-1:0] wr_data,
   input  wire  [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : prim_mst_ram
`default_nettype wire

// File: hdl/prim_mst_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prim spanning tree key comparator
// Shared less-than unit for the minimum search and the neighbour relaxation.
// ----------------------------------------------------------------------------
module prim_mst_cmp
   import prim_mst_pkg::*;
(
   input  wire cmp_ctl_type   ctl,
   input  wire vert_word_type word,
   output logic               take
);

   logic [KEY_W-1:0] lhs;
   logic [KEY_W-1:0] rhs;

   // In the search the vertex key is tested against the best so far; in the
   // relaxation the edge weight is tested against the vertex key.
   assign lhs  = ctl.relax ? ctl.weight : word.key;
   assign rhs  = ctl.relax ? word.key : ctl.best_key;
   assign take = !word.visited && !(ctl.relax && ctl.is_best) && (lhs < rhs);

endmodule : prim_mst_cmp
`default_nettype wire

// File: hdl/prim_minimum_spanning_tree_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prim minimum spanning tree
// Dense Prim search over an adjacency matrix held in RAM, one shared comparator.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Word
//   req_*     in         req_valid/req_stall  load one edge weight, or run from a root
//   rsp_*     out        rsp_valid/rsp_stall  one vertex: key, parent plus one, reached
//
// A load word is taken only while idle and writes the weight matrix RAM.
// A run word starts an initialisation sweep of the vertex RAM, then per tree
// vertex one pass of the comparator over all keys and one over the chosen
// matrix row, then a final search and the read-out of N result words.
// The vertex RAM read port and the single comparator set the pace of a run.
// Reset is synchronous and active high; the matrix is not cleared by it.
// req_stall is high from a run word until its last result word is taken, and
// each result word holds for as long as rsp_stall is high.
//
module prim_minimum_spanning_tree_top
   import prim_mst_pkg::*;
#(
   parameter int unsigned VERTEX_COUNT = VERTEX_COUNT_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire               req_operation,
   input  wire  [VTX_W-1:0]  req_row_vertex,
   input  wire  [VTX_W-1:0]  req_column_vertex,
   input  wire  [KEY_W-1:0]  req_edge_weight,
   input  wire  [VTX_W-1:0]  req_root_vertex,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [VTX_W-1:0]  rsp_vertex_index,
   output logic [KEY_W-1:0]  rsp_key_weight,
   output logic [PAR_W-1:0]  rsp_parent_plus_one,
   output logic              rsp_reached,
   output logic              rsp_last_result
);

   // Vertex index width, counter width (holds N itself) and matrix address width.
   localparam int unsigned IW = $clog2(VERTEX_COUNT);
   localparam int unsigned CW = $clog2(VERTEX_COUNT + 1);
   localparam int unsigned AW = $clog2(VERTEX_COUNT * VERTEX_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_RELAX,
      ST_OUT_READ,
      ST_OUT_LOAD,
      ST_OUT_WAIT
   } state_type;

   state_type        state_ff,      state_in;
   logic [CW-1:0]    cnt_ff,        cnt_in;
   logic [VTX_W-1:0] root_ff,       root_in;
   logic [IW-1:0]    best_idx_ff,   best_idx_in;
   logic [KEY_W-1:0] best_key_ff,   best_key_in;
   logic             found_ff,      found_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   logic [VTX_W-1:0] rsp_index_ff,  rsp_index_in;
   logic [KEY_W-1:0] rsp_key_ff,    rsp_key_in;
   logic [PAR_W-1:0] rsp_parent_ff, rsp_parent_in;
   logic             rsp_reached_ff, rsp_reached_in;
   logic             rsp_last_ff,   rsp_last_in;

   logic             req_take;
   logic             load_in_range;
   logic             wm_we;
   logic [AW-1:0]    wm_waddr;
   logic [AW-1:0]    wm_raddr;
   logic [KEY_W-1:0] wm_rdata;

   logic             vr_we;
   logic [IW-1:0]    vr_waddr;
   vert_word_type    vr_wdata;
   logic [IW-1:0]    vr_raddr;
   logic [VERT_W-1:0] vr_rdata;
   vert_word_type    vr_word;

   logic [IW-1:0]    addr_lim;
   logic [CW-1:0]    cnt_m1;
   logic [IW-1:0]    prev_idx;
   logic [IW:0]      best_p1;
   logic             cnt_at_end;
   cmp_ctl_type      cmp_ctl;
   logic             cmp_take;

   // ------------------------------------------------------------------------
   // Matrix load path: a word is taken only while idle.
   // ------------------------------------------------------------------------
   assign req_take      = req_valid && (state_ff == ST_IDLE);
   assign load_in_range = (8'(req_row_vertex) < 8'(VERTEX_COUNT)) &&
                          (8'(req_column_vertex) < 8'(VERTEX_COUNT));
   assign wm_we         = req_take && (req_operation == OP_LOAD) && load_in_range;
   assign wm_waddr      = AW'(IW'(req_row_vertex)) * AW'(VERTEX_COUNT) +
                          AW'(IW'(req_column_vertex));

   // The sweep counters run to N so that the last read can be compared;
   // at that point the address is folded back to zero to stay in range.
   assign cnt_at_end = (cnt_ff == CW'(VERTEX_COUNT));
   assign addr_lim   = cnt_at_end ? '0 : cnt_ff[IW-1:0];
   assign cnt_m1     = cnt_ff - CW'(1);
   assign prev_idx   = cnt_m1[IW-1:0];
   assign best_p1    = {1'b0, best_idx_ff} + (IW+1)'(1);

   assign wm_raddr = AW'(best_idx_ff) * AW'(VERTEX_COUNT) + AW'(addr_lim);
   assign vr_raddr = addr_lim;
   assign vr_word  = vert_word_type'(vr_rdata);

   prim_mst_ram #(
      .DEPTH (VERTEX_COUNT * VERTEX_COUNT),
      .WIDTH (KEY_W)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wm_we),
      .wr_addr (wm_waddr),
      .wr_data (req_edge_weight),
      .rd_addr (wm_raddr),
      .rd_data (wm_rdata)
   );

   prim_mst_ram #(
      .DEPTH (VERTEX_COUNT),
      .WIDTH (VERT_W)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vr_we),
      .wr_addr (vr_waddr),
      .wr_data (vr_wdata),
      .rd_addr (vr_raddr),
      .rd_data (vr_rdata)
   );

   assign cmp_ctl.relax    = (state_ff == ST_RELAX);
   assign cmp_ctl.is_best  = (prev_idx == best_idx_ff);
   assign cmp_ctl.best_key = best_key_ff;
   assign cmp_ctl.weight   = wm_rdata;

   prim_mst_cmp u_cmp (
      .ctl  (cmp_ctl),
      .word (vr_word),
      .take (cmp_take)
   );

   // ------------------------------------------------------------------------
   // Sequencer. Read data of the vertex and matrix RAMs arrives in the cycle
   // after the address, so every sweep acts on the entry before the counter.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      root_in        = root_ff;
      best_idx_in    = best_idx_ff;
      best_key_in    = best_key_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_parent_in  = rsp_parent_ff;
      rsp_reached_in = rsp_reached_ff;
      rsp_last_in    = rsp_last_ff;
      vr_we          = 1'b0;
      vr_waddr       = addr_lim;
      vr_wdata       = vr_word;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_operation == OP_RUN)) begin
               root_in  = req_root_vertex;
               cnt_in   = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            // Every vertex starts unvisited with no parent; only an in-range
            // root gets a zero key.
            vr_we            = 1'b1;
            vr_waddr         = cnt_ff[IW-1:0];
            vr_wdata.visited = 1'b0;
            vr_wdata.parent  = '0;
            vr_wdata.key     = (8'(cnt_ff) == 8'(root_ff)) ? '0 : KEY_NONE;
            cnt_in           = cnt_ff + CW'(1);
            if (cnt_ff == CW'(VERTEX_COUNT - 1)) begin
               cnt_in      = '0;
               found_in    = 1'b0;
               best_key_in = KEY_NONE;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((cnt_ff != '0) && cmp_take) begin
               best_key_in = vr_word.key;
               best_idx_in = prev_idx;
               found_in    = 1'b1;
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_at_end) begin
               cnt_in   = '0;
               state_in = found_in ? ST_RELAX : ST_OUT_READ;
            end
         end
         ST_RELAX: begin
            if (cnt_ff != '0) begin
               vr_waddr = prev_idx;
               if (cmp_ctl.is_best) begin
                  vr_we            = 1'b1;
                  vr_wdata.visited = 1'b1;
               end else if (cmp_take) begin
                  vr_we            = 1'b1;
                  vr_wdata.visited = 1'b0;
                  vr_wdata.parent  = PAR_W'(best_p1);
                  vr_wdata.key     = wm_rdata;
               end
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_at_end) begin
               cnt_in      = '0;
               found_in    = 1'b0;
               best_key_in = KEY_NONE;
               state_in    = ST_SCAN;
            end
         end
         ST_OUT_READ: begin
            state_in = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            rsp_valid_in   = 1'b1;
            rsp_index_in   = VTX_W'(cnt_ff);
            rsp_key_in     = vr_word.key;
            rsp_parent_in  = vr_word.parent;
            rsp_reached_in = vr_word.visited;
            rsp_last_in    = (cnt_ff == CW'(VERTEX_COUNT - 1));
            state_in       = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + CW'(1);
                  state_in = ST_OUT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff         <= cnt_in;
      root_ff        <= root_in;
      best_idx_ff    <= best_idx_in;
      best_key_ff    <= best_key_in;
      found_ff       <= found_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_parent_ff  <= rsp_parent_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vertex_index    = rsp_index_ff;
   assign rsp_key_weight      = rsp_key_ff;
   assign rsp_parent_plus_one = rsp_parent_ff;
   assign rsp_reached         = rsp_reached_ff;
   assign rsp_last_result     = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation == OP_RUN)) |=> req_stall)
      else $error("run word did not block the input channel");

   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_result) |=> (!req_stall && !rsp_valid))
      else $error("block not idle after the last result word");

   a_relax_has_key: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELAX) |-> (found_ff && (best_key_ff < KEY_NONE)))
      else $error("relaxation started without a reachable vertex");

   a_no_result_in_search: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) || (state_ff == ST_RELAX) || (state_ff == ST_INIT))
      |-> !rsp_valid)
      else $error("result word shown while the tree is being built");

endmodule : prim_minimum_spanning_tree_top
`default_nettype wire
